/* src/mme_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery exponent unit package
// Shared constants, operation codes and controller/datapath bundles.
// ----------------------------------------------------------------------------
package mme_pkg;

   localparam logic [31:0] MODULUS = 32'd1000000007;

   // p^-1 mod 2^32 by Newton iteration; every step doubles the correct bits
   function automatic logic [31:0] calc_inverse();
      logic [31:0] v;
      logic [31:0] t;
      int          k;
      v = 32'd1;
      for (k = 0; k < 6; k++) begin
         t = v * MODULUS;
         v = v * (32'd2 - t);
      end
      return v;
   endfunction

   localparam logic [31:0] MONT_INV  = calc_inverse();
   localparam logic [63:0] NEG_MOD   = 64'd0 - {32'd0, MODULUS};
   localparam logic [31:0] R_SQUARED = 32'(NEG_MOD % {32'd0, MODULUS});

   // Montgomery product being worked on
   localparam logic [2:0] OP_BASE_IN  = 3'd0;
   localparam logic [2:0] OP_ACC_INIT = 3'd1;
   localparam logic [2:0] OP_ACC_MUL  = 3'd2;
   localparam logic [2:0] OP_SQUARE   = 3'd3;
   localparam logic [2:0] OP_OUT      = 3'd4;

   // step within one product
   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_RED  = 2'd2;
   localparam logic [1:0] PH_FIX  = 2'd3;

   typedef struct packed {
      logic       load;
      logic [1:0] phase;
      logic [2:0] op;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic exp_zero;
      logic exp_lsb;
      logic out_free;
   } status_type;

endpackage

/* src/mme_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery exponent unit channels
// Valid/ready request and response channels.
// ----------------------------------------------------------------------------
interface mme_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] base;
   logic [30:0] exponent;

   modport source (output valid, output base, output exponent, input ready);
   modport sink   (input valid, input base, input exponent, output ready);
endinterface

interface mme_rsp_if;
   logic        valid;
   logic        ready;
   logic [29:0] power;

   modport source (output valid, output power, input ready);
   modport sink   (input valid, input power, output ready);
endinterface

/* src/mme_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery exponent controller
// Sequences Montgomery square-and-multiply, one step a cycle unless emit stalls.
// ----------------------------------------------------------------------------
module mme_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  mme_pkg::status_type status,
   output mme_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_RED  = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [2:0] scan_op;

   // next product while scanning the exponent
   always_comb begin
      if (status.exp_zero) begin
         scan_op = mme_pkg::OP_OUT;
      end else if (status.exp_lsb) begin
         scan_op = mme_pkg::OP_ACC_MUL;
      end else begin
         scan_op = mme_pkg::OP_SQUARE;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      cmd.load  = 1'b0;
      cmd.phase = mme_pkg::PH_NONE;
      cmd.op    = op_ff;
      cmd.emit  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = mme_pkg::OP_BASE_IN;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.phase = mme_pkg::PH_MUL;
            state_in  = S_RED;
         end
         S_RED: begin
            cmd.phase = mme_pkg::PH_RED;
            state_in  = S_FIX;
         end
         S_FIX: begin
            cmd.phase = mme_pkg::PH_FIX;
            state_in  = S_MUL;
            unique case (op_ff)
               mme_pkg::OP_BASE_IN: op_in = mme_pkg::OP_ACC_INIT;
               mme_pkg::OP_OUT:     state_in = S_EMIT;
               default:             op_in = scan_op;
            endcase
         end
         S_EMIT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= mme_pkg::OP_BASE_IN;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

/* src/mme_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery exponent datapath
// Operand registers, one shared 32x32 multiplier and the output register.
// ----------------------------------------------------------------------------
module mme_datapath (
   input  logic                clock,
   input  logic                reset,
   input  mme_pkg::cmd_type    cmd,
   output mme_pkg::status_type status,
   input  logic [31:0]         req_base,
   input  logic [30:0]         req_exponent,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [29:0]         rsp_power
);

   logic [31:0] base_ff, base_in;
   logic [31:0] acc_ff, acc_in;
   logic [30:0] exp_ff, exp_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] q_ff, q_in;
   logic [29:0] power_ff, power_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] op_a, op_b;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_full;
   logic [32:0] red_sum;
   logic [31:0] fixed;

   always_comb begin
      unique case (cmd.op)
         mme_pkg::OP_BASE_IN: begin
            op_a = base_ff;
            op_b = mme_pkg::R_SQUARED;
         end
         mme_pkg::OP_ACC_INIT: begin
            op_a = 32'd1;
            op_b = mme_pkg::R_SQUARED;
         end
         mme_pkg::OP_ACC_MUL: begin
            op_a = acc_ff;
            op_b = base_ff;
         end
         mme_pkg::OP_SQUARE: begin
            op_a = base_ff;
            op_b = base_ff;
         end
         default: begin
            op_a = acc_ff;
            op_b = 32'd1;
         end
      endcase
   end

   // shared multiplier: product, then quotient digit, then correction
   always_comb begin
      case (cmd.phase)
         mme_pkg::PH_RED: begin
            mul_a = prod_ff[31:0];
            mul_b = mme_pkg::MONT_INV;
         end
         mme_pkg::PH_FIX: begin
            mul_a = q_ff;
            mul_b = mme_pkg::MODULUS;
         end
         default: begin
            mul_a = op_a;
            mul_b = op_b;
         end
      endcase
   end

   assign mul_full = 64'(mul_a) * 64'(mul_b);
   assign red_sum  = {1'b0, prod_ff[63:32]} + {1'b0, mme_pkg::MODULUS}
                   - {1'b0, mul_full[63:32]};
   assign fixed    = (acc_ff >= mme_pkg::MODULUS) ? acc_ff - mme_pkg::MODULUS : acc_ff;

   always_comb begin
      base_in      = base_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      power_in     = power_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         base_in = req_base;
         exp_in  = req_exponent;
      end
      case (cmd.phase)
         mme_pkg::PH_MUL: begin
            prod_in = mul_full;
            // advance the exponent early so the controller sees it at the end
            if (cmd.op == mme_pkg::OP_ACC_MUL) begin
               exp_in = {exp_ff[30:1], 1'b0};
            end else if (cmd.op == mme_pkg::OP_SQUARE) begin
               exp_in = exp_ff >> 1;
            end
         end
         mme_pkg::PH_RED: begin
            q_in = mul_full[31:0];
         end
         mme_pkg::PH_FIX: begin
            if (cmd.op == mme_pkg::OP_BASE_IN || cmd.op == mme_pkg::OP_SQUARE) begin
               base_in = red_sum[31:0];
            end else begin
               acc_in = red_sum[31:0];
            end
         end
         default: begin
         end
      endcase
      if (cmd.emit) begin
         power_in     = fixed[29:0];
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      acc_ff   <= acc_in;
      exp_ff   <= exp_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      power_ff <= power_in;
   end

   assign status.exp_zero = (exp_ff == 31'd0);
   assign status.exp_lsb  = exp_ff[0];
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_power       = power_ff;

endmodule

/* src/montgomery_mod_exponent_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery modular exponent unit
// power = base ^ exponent mod 1000000007, square-and-multiply in Montgomery form.
//
//   channel   dir   payload                         handshake
//   req_chan  in    base[31:0], exponent[30:0]      valid/ready
//   rsp_chan  out   power[29:0]                     valid/ready
//
// Each Montgomery product runs through the multiply, reduce and fix steps on the single 32x32 multiplier.
// One request is worked on at a time; the next is taken while a response waits.
// Reset is synchronous and clears the controller and the response valid.
// A stalled response holds the unit in its emit step until the register frees.
// ----------------------------------------------------------------------------
module montgomery_mod_exponent_unit (
   input logic   clock,
   input logic   reset,
   mme_req_if.sink   req_chan,
   mme_rsp_if.source rsp_chan
);

   mme_pkg::cmd_type    cmd;
   mme_pkg::status_type status;

   mme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mme_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_base     (req_chan.base),
      .req_exponent (req_chan.exponent),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_power    (rsp_chan.power)
   );

endmodule

/* src/mme_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery exponent unit checker
// Port-level properties of the exponent unit, bound to the top level.
// ----------------------------------------------------------------------------
module mme_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [29:0] rsp_power
);

   // a response stays until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_power))
      else $error("response changed while stalled");

   // results are fully reduced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power < 30'(mme_pkg::MODULUS))
      else $error("power not reduced below the modulus");

   // one request in flight: ready drops after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind montgomery_mod_exponent_unit mme_checker u_mme_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_power (rsp_chan.power)
);

/* tb/tb_montgomery_mod_exponent_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Montgomery modular exponent unit testbench
// Sends base/exponent requests through the request channel and checks every
// power against a Montgomery square-and-multiply predictor (p = 1000000007).
// Both channels idle in random bursts, and the sender waits for the unit to
// drain now and then.
// ----------------------------------------------------------------------------
module tb_montgomery_mod_exponent_unit;

   localparam logic [31:0] PRIME       = 32'd1000000007;
   localparam int          CYCLE_LIMIT = 1500000;
   localparam int          DRAIN_WAIT  = 250;
   localparam int          CALM_TAIL   = 200;
   localparam int          RANDOM_REQS = 1330;

   // p^-1 mod 2^32, lifted one bit at a time
   function automatic logic [31:0] prime_inverse();
      logic [31:0] inv;
      logic [31:0] prod;
      int          i;
      inv = 32'd1;
      for (i = 1; i < 32; i++) begin
         prod = inv * PRIME;
         if (prod[i]) inv[i] = 1'b1;
      end
      return inv;
   endfunction

   // 2^64 mod p, from (2^32 mod p) squared
   function automatic logic [31:0] radix_sq_mod();
      logic [63:0] r1;
      logic [63:0] r2;
      r1 = 64'h1_0000_0000 % {32'd0, PRIME};
      r2 = (r1 * r1) % {32'd0, PRIME};
      return r2[31:0];
   endfunction

   localparam logic [31:0] P_INV  = prime_inverse();
   localparam logic [31:0] R2_MOD = radix_sq_mod();

   typedef struct {
      logic [31:0] base;
      logic [30:0] exponent;
      bit          drain_first;
   } exp_request_type;

   logic clock;
   logic reset;

   mme_req_if req_chan ();
   mme_rsp_if rsp_chan ();

   montgomery_mod_exponent_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   exp_request_type pending_requests[$];
   logic [29:0]     expected_powers[$];
   exp_request_type next_req;

   int issued_cnt;
   int received_cnt;
   int total_requests;
   int mismatch_cnt;
   int cycle_cnt;
   int send_gap;
   int recv_stall;

   wire calm_tail = (issued_cnt + CALM_TAIL >= total_requests);

   // w * 2^-32 mod p, left in 0..2p-1 when w is below p * 2^32
   function automatic logic [31:0] mont_fold(logic [63:0] w);
      logic [31:0] q;
      logic [63:0] qp;
      logic [63:0] r;
      q  = w[31:0] * P_INV;
      qp = {32'd0, q} * {32'd0, PRIME};
      r  = {32'd0, w[63:32]} + {32'd0, PRIME} - {32'd0, qp[63:32]};
      return r[31:0];
   endfunction

   function automatic logic [31:0] mont_product(logic [31:0] a, logic [31:0] b);
      return mont_fold({32'd0, a} * {32'd0, b});
   endfunction

   function automatic logic [29:0] predict_power(logic [31:0] base, logic [30:0] exponent);
      logic [31:0] sq;
      logic [31:0] acc;
      logic [31:0] res;
      logic [30:0] e;
      sq  = mont_fold({32'd0, base} * {32'd0, R2_MOD});
      acc = mont_fold({32'd0, R2_MOD});
      e   = exponent;
      while (e != 31'd0) begin
         if (e[0]) acc = mont_product(acc, sq);
         e  = e >> 1;
         sq = mont_product(sq, sq);
      end
      res = mont_fold({32'd0, acc});
      if (res >= PRIME) res = res - PRIME;
      return res[29:0];
   endfunction

   task automatic add_request(logic [31:0] base, logic [30:0] exponent, bit drain_first);
      exp_request_type r;
      r.base        = base;
      r.exponent    = exponent;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_powers.push_back(predict_power(req_chan.base, req_chan.exponent));
            issued_cnt <= issued_cnt + 1;
         end
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= send_gap - 1;
         end else if (pending_requests.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (pending_requests[0].drain_first &&
                      (req_chan.valid || issued_cnt != received_cnt)) begin
            // hold until every outstanding power has come back
            req_chan.valid <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= $urandom_range(1, 14) - 1;
         end else begin
            next_req           = pending_requests.pop_front();
            req_chan.valid    <= 1'b1;
            req_chan.base     <= next_req.base;
            req_chan.exponent <= next_req.exponent;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            received_cnt <= received_cnt + 1;
            if (expected_powers.size() == 0) begin
               if (mismatch_cnt < 10)
                  $display("unexpected power %0d with nothing outstanding", rsp_chan.power);
               mismatch_cnt <= mismatch_cnt + 1;
            end else begin
               if (rsp_chan.power !== expected_powers[0]) begin
                  if (mismatch_cnt < 10)
                     $display("power mismatch: expected %0d, got %0d",
                              expected_powers[0], rsp_chan.power);
                  mismatch_cnt <= mismatch_cnt + 1;
               end
               void'(expected_powers.pop_front());
            end
         end
         if (recv_stall > 0) begin
            rsp_chan.ready <= 1'b0;
            recv_stall     <= recv_stall - 1;
         end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
            rsp_chan.ready <= 1'b0;
            recv_stall     <= $urandom_range(1, 14) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] b;
      logic [31:0] e;
      int          k;
      int          n;
      int          i;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.base     = '0;
      req_chan.exponent = '0;
      rsp_chan.ready    = 1'b0;
      issued_cnt        = 0;
      received_cnt      = 0;
      mismatch_cnt      = 0;
      cycle_cnt         = 0;

      // zero exponent, also on a multiple of p
      add_request(32'd0, 31'd0, 1'b0);
      add_request(PRIME, 31'd0, 1'b0);
      add_request(32'hFFFF_FFFF, 31'd0, 1'b0);
      // multiples of p with a nonzero exponent come out as zero
      add_request(PRIME, 31'h7FFF_FFFF, 1'b0);
      add_request(32'd2000000014, 31'd5, 1'b0);
      add_request(32'd4000000028, 31'd12345, 1'b0);
      add_request(32'd0, 31'd1, 1'b0);
      // field extremes
      add_request(32'd1, 31'h7FFF_FFFF, 1'b0);
      add_request(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b0);
      add_request(32'hFFFF_FFFF, 31'd1, 1'b0);
      add_request(32'h8000_0000, 31'h4000_0000, 1'b0);
      add_request(PRIME - 32'd1, 31'd2, 1'b0);
      add_request(PRIME - 32'd1, 31'h7FFF_FFFF, 1'b0);
      add_request(PRIME + 32'd1, 31'h7FFF_FFFF, 1'b0);
      add_request(32'd2, 31'd30, 1'b0);
      add_request(32'd2, 31'd31, 1'b0);
      add_request(32'd3, 31'h5555_5555, 1'b0);
      add_request(32'd7, 31'h2AAA_AAAA, 1'b0);
      add_request(32'd12345, 31'd1, 1'b0);
      add_request(32'd10, 31'd9, 1'b1);

      for (i = 0; i < RANDOM_REQS; i++) begin
         case ($urandom_range(0, 5))
            0, 1: b = $urandom;
            2: b = $urandom_range(0, 16);
            3: begin
               k = $urandom_range(0, 4);
               if (k == 0) b = $urandom_range(0, 3);
               else b = PRIME * k + $urandom_range(0, 6) - 3;
            end
            4: b = PRIME - 32'd1 - $urandom_range(0, 3);
            default: b = 32'hFFFF_FFFF - $urandom_range(0, 15);
         endcase
         case ($urandom_range(0, 5))
            0, 1: e = $urandom;
            2: e = $urandom_range(0, 70);
            3: e = 32'd1 << $urandom_range(0, 30);
            4: begin
               n = $urandom_range(1, 31);
               e = (32'd1 << n) - 32'd1;
            end
            default: e = $urandom & $urandom & $urandom;
         endcase
         add_request(b, e[30:0], (i % 97) == 50);
      end
      total_requests = pending_requests.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      @(posedge clock);
      while (pending_requests.size() != 0 || req_chan.valid || issued_cnt != received_cnt)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatch_cnt == 0 && expected_powers.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
